// ===== hdl/kclc_pkg.sv =====
package kclc_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int COUNT_W = 3;
   localparam int TONE_W = 11;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] LAST_DIGIT = COUNT_W'(CODE_DIGITS - 1);

   localparam logic [0:0] CSR_MAX_FAILED_TRIES = 1'd0;
   localparam logic [0:0] CSR_LOCKOUT_TICKS = 1'd1;

   localparam logic [3:0] MAX_FAILED_RESET = 4'd3;
   localparam logic [15:0] LOCKOUT_RESET = 16'd100;

   localparam logic OP_KEY = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [3:0] KEY_VERIFY = 4'd1;
   localparam logic [3:0] KEY_SET = 4'd2;
   localparam logic [3:0] KEY_CHANGE = 4'd3;
   localparam logic [3:0] KEY_SOUND = 4'd4;
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_DOWN = 4'd11;

   localparam logic [TONE_W-1:0] TONE_DOWN = 11'd494;
   localparam logic [TONE_W-1:0] TONE_WRONG = 11'd1000;
   localparam logic [TONE_W-1:0] TONE_LOCKOUT = 11'd500;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_VERIFY = 3'd1,
      MODE_SET = 3'd2,
      MODE_OLD = 3'd3,
      MODE_NEW = 3'd4,
      MODE_LOCKED = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      EV_NONE = 4'd0,
      EV_DIGIT = 4'd1,
      EV_STORED = 4'd2,
      EV_OPEN = 4'd3,
      EV_WRONG = 4'd4,
      EV_LOCKED = 4'd5,
      EV_NOT_SET = 4'd6,
      EV_ALREADY_SET = 4'd7,
      EV_SOUND = 4'd8,
      EV_SCROLLED = 4'd9,
      EV_UNLOCKED = 4'd10,
      EV_OLD_OK = 4'd11,
      EV_STARTED = 4'd12
   } event_type;

   typedef struct packed {
      logic op;
      logic [3:0] key_code;
   } req_word_type;

   typedef struct packed {
      logic [3:0] event_res;
      logic [TONE_W-1:0] tone_hz;
      logic [1:0] menu_position;
      logic sound_enabled;
      logic [2:0] digits_entered;
      logic [2:0] lock_mode;
   } rsp_word_type;

   typedef logic [CODE_DIGITS-1:0][3:0] code_word_type;

   typedef struct packed {
      mode_type mode;
      logic code_valid;
      logic [COUNT_W-1:0] entry_count;
      logic [3:0] failed_count;
      logic sound;
      logic [1:0] menu;
      logic [15:0] lock_counter;
   } lock_state_type;

   typedef struct packed {
      logic digit_we;
      logic store_we;
   } code_ctl_type;

   function automatic logic [TONE_W-1:0] digit_tone(input logic [3:0] key);
      logic [TONE_W-1:0] hz;
      unique case (key)
         4'd0: hz = 11'd523;
         4'd1: hz = 11'd587;
         4'd2: hz = 11'd659;
         4'd3: hz = 11'd698;
         4'd4: hz = 11'd784;
         4'd5: hz = 11'd880;
         4'd6: hz = 11'd987;
         4'd7: hz = 11'd1046;
         4'd8: hz = 11'd1175;
         4'd9: hz = 11'd1319;
         default: hz = '0;
      endcase
      return hz;
   endfunction

   function automatic logic [TONE_W-1:0] menu_tone(input logic [3:0] key);
      logic [TONE_W-1:0] hz;
      unique case (key)
         KEY_VERIFY: hz = 11'd587;
         KEY_SET: hz = 11'd659;
         KEY_CHANGE: hz = 11'd698;
         KEY_SOUND: hz = 11'd784;
         default: hz = '0;
      endcase
      return hz;
   endfunction

endpackage

// ===== hdl/keypad_code_lock_controller_unit.sv =====
// Keypad code lock. Each word on req_ is a key press or a timer tick; each one
// yields exactly one rsp_ word with the event, the buzzer tone it starts and the
// lock status after it. A word goes from the input register through kclc_step
// to the result register; a new word is taken every cycle while the result side
// keeps up; rsp_ready low stalls the single result register, then the input
// register. The code is four digits, held in flip-flops. Write csr_ registers
// (0 max failed tries, 1 lockout ticks) only while no word is in flight.
module keypad_code_lock_controller_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kclc_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kclc_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [kclc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam kclc_pkg::lock_state_type STATE_RESET = '{
      mode: kclc_pkg::MODE_IDLE,
      code_valid: 1'b0,
      entry_count: '0,
      failed_count: '0,
      sound: 1'b1,
      menu: '0,
      lock_counter: '0
   };

   logic in_valid_ff;
   kclc_pkg::req_word_type in_word_ff;
   logic rsp_valid_ff;
   kclc_pkg::rsp_word_type rsp_word_ff;
   kclc_pkg::lock_state_type state_ff;
   kclc_pkg::lock_state_type state_in;
   kclc_pkg::code_word_type stored_code_ff;
   kclc_pkg::code_word_type entry_digits_ff;
   kclc_pkg::code_word_type entry_upd;
   kclc_pkg::code_ctl_type code_ctl;
   kclc_pkg::rsp_word_type rsp_word_in;
   logic [3:0] max_failed_ff;
   logic [15:0] lockout_ticks_ff;
   logic advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   kclc_step u_step (
      .word             (in_word_ff),
      .state            (state_ff),
      .stored_code      (stored_code_ff),
      .entry_digits     (entry_digits_ff),
      .max_failed_tries (max_failed_ff),
      .lockout_ticks    (lockout_ticks_ff),
      .state_next       (state_in),
      .entry_upd        (entry_upd),
      .code_ctl         (code_ctl),
      .rsp              (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
         max_failed_ff <= kclc_pkg::MAX_FAILED_RESET;
         lockout_ticks_ff <= kclc_pkg::LOCKOUT_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               kclc_pkg::CSR_MAX_FAILED_TRIES: max_failed_ff <= csr_wdata[3:0];
               kclc_pkg::CSR_LOCKOUT_TICKS:    lockout_ticks_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_word_ff <= req_word;
      if (advance) rsp_word_ff <= rsp_word_in;
      if (advance && code_ctl.digit_we) entry_digits_ff <= entry_upd;
      if (advance && code_ctl.store_we) stored_code_ff <= entry_upd;
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.entry_count <= kclc_pkg::LAST_DIGIT)
      else $error("entry count past code length");

   a_locked_no_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == kclc_pkg::MODE_LOCKED |-> state_ff.entry_count == '0)
      else $error("digits pending while locked");

   a_code_valid_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.code_valid |=> state_ff.code_valid)
      else $error("stored code lost its valid flag");

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(state_ff))
      else $error("word dropped or state moved under stall");

   a_store_only_in_entry: assert property (@(posedge clock) disable iff (reset)
      advance && code_ctl.store_we |->
         (state_ff.mode == kclc_pkg::MODE_SET || state_ff.mode == kclc_pkg::MODE_NEW))
      else $error("code stored outside set or change");

endmodule

// ===== hdl/kclc_step.sv =====
module kclc_step (
   input  kclc_pkg::req_word_type   word,
   input  kclc_pkg::lock_state_type state,
   input  kclc_pkg::code_word_type  stored_code,
   input  kclc_pkg::code_word_type  entry_digits,
   input  logic [3:0]               max_failed_tries,
   input  logic [15:0]              lockout_ticks,
   output kclc_pkg::lock_state_type state_next,
   output kclc_pkg::code_word_type  entry_upd,
   output kclc_pkg::code_ctl_type   code_ctl,
   output kclc_pkg::rsp_word_type   rsp
);

   logic is_key;
   logic is_digit;
   logic is_last;
   logic in_entry;
   logic match;
   logic start_ok;
   logic lock_hit;
   logic tick_done;
   logic [3:0] fail_inc;
   logic [kclc_pkg::IDX_W-1:0] digit_idx;
   logic [kclc_pkg::TONE_W-1:0] tone_raw;
   kclc_pkg::mode_type mode_next;
   kclc_pkg::event_type ev;

   assign is_key = (word.op == kclc_pkg::OP_KEY);
   assign is_digit = is_key && (word.key_code <= kclc_pkg::KEY_LAST_DIGIT);
   assign is_last = (state.entry_count == kclc_pkg::LAST_DIGIT);
   assign in_entry = (state.mode == kclc_pkg::MODE_VERIFY) || (state.mode == kclc_pkg::MODE_SET)
                  || (state.mode == kclc_pkg::MODE_OLD) || (state.mode == kclc_pkg::MODE_NEW);
   assign digit_idx = state.entry_count[kclc_pkg::IDX_W-1:0];
   assign fail_inc = (state.failed_count == 4'hF) ? 4'hF : state.failed_count + 4'd1;
   assign lock_hit = (fail_inc >= max_failed_tries);
   assign tick_done = (state.lock_counter <= 16'd1);
   assign match = (entry_upd == stored_code);

   always_comb begin
      entry_upd = entry_digits;
      entry_upd[digit_idx] = word.key_code;
   end

   always_comb begin
      unique case (word.key_code)
         kclc_pkg::KEY_VERIFY: start_ok = state.code_valid;
         kclc_pkg::KEY_SET:    start_ok = !state.code_valid;
         kclc_pkg::KEY_CHANGE: start_ok = state.code_valid;
         default:              start_ok = 1'b0;
      endcase
   end

   // next mode
   always_comb begin
      mode_next = state.mode;
      unique case (state.mode)
         kclc_pkg::MODE_LOCKED: begin
            if (!is_key && tick_done) mode_next = kclc_pkg::MODE_IDLE;
         end
         kclc_pkg::MODE_IDLE: begin
            if (is_key && start_ok) begin
               priority case (word.key_code)
                  kclc_pkg::KEY_VERIFY: mode_next = kclc_pkg::MODE_VERIFY;
                  kclc_pkg::KEY_SET:    mode_next = kclc_pkg::MODE_SET;
                  default:              mode_next = kclc_pkg::MODE_OLD;
               endcase
            end
         end
         kclc_pkg::MODE_VERIFY: begin
            if (is_digit && is_last) begin
               mode_next = (!match && lock_hit) ? kclc_pkg::MODE_LOCKED : kclc_pkg::MODE_IDLE;
            end
         end
         kclc_pkg::MODE_OLD: begin
            if (is_digit && is_last) begin
               mode_next = match ? kclc_pkg::MODE_NEW : kclc_pkg::MODE_IDLE;
            end
         end
         kclc_pkg::MODE_SET, kclc_pkg::MODE_NEW: begin
            if (is_digit && is_last) mode_next = kclc_pkg::MODE_IDLE;
         end
         default: mode_next = kclc_pkg::MODE_IDLE;
      endcase
   end

   // data and result
   always_comb begin
      state_next = state;
      state_next.mode = mode_next;
      code_ctl = '0;
      ev = kclc_pkg::EV_NONE;
      tone_raw = '0;
      if (state.mode == kclc_pkg::MODE_LOCKED) begin
         if (!is_key) begin
            if (tick_done) begin
               state_next.lock_counter = '0;
               ev = kclc_pkg::EV_UNLOCKED;
            end else begin
               state_next.lock_counter = state.lock_counter - 16'd1;
            end
         end else begin
            ev = kclc_pkg::EV_LOCKED;
         end
      end else if (!is_key) begin
         ev = kclc_pkg::EV_NONE;
      end else if (state.mode == kclc_pkg::MODE_IDLE) begin
         if (word.key_code >= kclc_pkg::KEY_VERIFY && word.key_code <= kclc_pkg::KEY_SOUND) begin
            tone_raw = kclc_pkg::menu_tone(word.key_code);
            if (word.key_code == kclc_pkg::KEY_SOUND) begin
               state_next.sound = !state.sound;
               ev = kclc_pkg::EV_SOUND;
            end else if (!start_ok) begin
               ev = (word.key_code == kclc_pkg::KEY_SET) ? kclc_pkg::EV_ALREADY_SET
                                                         : kclc_pkg::EV_NOT_SET;
            end else begin
               state_next.entry_count = '0;
               ev = kclc_pkg::EV_STARTED;
            end
         end else if (word.key_code == kclc_pkg::KEY_DOWN) begin
            state_next.menu = state.menu + 2'd1;
            tone_raw = kclc_pkg::TONE_DOWN;
            ev = kclc_pkg::EV_SCROLLED;
         end
      end else if (in_entry && is_digit) begin
         code_ctl.digit_we = 1'b1;
         tone_raw = kclc_pkg::digit_tone(word.key_code);
         ev = kclc_pkg::EV_DIGIT;
         if (!is_last) begin
            state_next.entry_count = state.entry_count + 3'd1;
         end else begin
            state_next.entry_count = '0;
            if (state.mode == kclc_pkg::MODE_SET || state.mode == kclc_pkg::MODE_NEW) begin
               code_ctl.store_we = 1'b1;
               state_next.code_valid = 1'b1;
               ev = kclc_pkg::EV_STORED;
            end else if (match) begin
               state_next.failed_count = '0;
               ev = (state.mode == kclc_pkg::MODE_VERIFY) ? kclc_pkg::EV_OPEN
                                                          : kclc_pkg::EV_OLD_OK;
            end else if (state.mode == kclc_pkg::MODE_VERIFY && lock_hit) begin
               state_next.failed_count = '0;
               state_next.lock_counter = lockout_ticks;
               tone_raw = kclc_pkg::TONE_LOCKOUT;
               ev = kclc_pkg::EV_LOCKED;
            end else begin
               if (state.mode == kclc_pkg::MODE_VERIFY) state_next.failed_count = fail_inc;
               tone_raw = kclc_pkg::TONE_WRONG;
               ev = kclc_pkg::EV_WRONG;
            end
         end
      end
   end

   always_comb begin
      rsp.event_res = ev;
      rsp.tone_hz = state.sound ? tone_raw : '0;
      rsp.menu_position = state_next.menu;
      rsp.sound_enabled = state_next.sound;
      rsp.digits_entered = state_next.entry_count;
      rsp.lock_mode = state_next.mode;
   end

endmodule

// ===== sim/tb_keypad_code_lock_controller_unit.sv =====
module tb_keypad_code_lock_controller_unit;
   import kclc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int WORDS_PER_PHASE = 210;
   localparam logic [TONE_W-1:0] DIGIT_HZ [10] = '{
      11'd523, 11'd587, 11'd659, 11'd698, 11'd784,
      11'd880, 11'd987, 11'd1046, 11'd1175, 11'd1319
   };
   localparam logic [TONE_W-1:0] MENU_HZ [5] = '{
      11'd0, 11'd587, 11'd659, 11'd698, 11'd784
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted lock state
   mode_type pred_mode = MODE_IDLE;
   logic [CODE_DIGITS-1:0][3:0] pred_code = '0;
   logic [CODE_DIGITS-1:0][3:0] pred_entry = '0;
   logic pred_code_valid = 1'b0;
   logic [2:0] pred_count = '0;
   logic [3:0] pred_failed = '0;
   logic pred_sound = 1'b1;
   logic [1:0] pred_menu = '0;
   logic [15:0] pred_lock_left = '0;
   logic [3:0] cfg_max_tries = MAX_FAILED_RESET;
   logic [15:0] cfg_lockout = LOCKOUT_RESET;

   rsp_word_type lock_results[$];
   rsp_word_type want_word;
   int errors = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;
   bit match_plan = 1'b1;

   keypad_code_lock_controller_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [TONE_W-1:0] gate_hz(input logic [TONE_W-1:0] hz);
      return pred_sound ? hz : '0;
   endfunction

   function automatic rsp_word_type predict_lock(input req_word_type w);
      rsp_word_type r;
      event_type ev;
      logic [TONE_W-1:0] hz;
      ev = EV_NONE;
      hz = '0;
      if (pred_mode == MODE_LOCKED) begin
         if (w.op == OP_TICK) begin
            if (pred_lock_left <= 16'd1) begin
               pred_lock_left = '0;
               pred_mode = MODE_IDLE;
               ev = EV_UNLOCKED;
            end else begin
               pred_lock_left = pred_lock_left - 16'd1;
            end
         end else begin
            ev = EV_LOCKED;
         end
      end else if (w.op == OP_TICK) begin
         ev = EV_NONE;
      end else if (pred_mode == MODE_IDLE) begin
         if (w.key_code >= KEY_VERIFY && w.key_code <= KEY_SOUND) begin
            hz = gate_hz(MENU_HZ[w.key_code]);
            if (w.key_code == KEY_SOUND) begin
               pred_sound = ~pred_sound;
               ev = EV_SOUND;
            end else if (w.key_code == KEY_SET && pred_code_valid) begin
               ev = EV_ALREADY_SET;
            end else if (w.key_code != KEY_SET && !pred_code_valid) begin
               ev = EV_NOT_SET;
            end else begin
               if (w.key_code == KEY_VERIFY) pred_mode = MODE_VERIFY;
               else if (w.key_code == KEY_SET) pred_mode = MODE_SET;
               else pred_mode = MODE_OLD;
               pred_count = '0;
               ev = EV_STARTED;
            end
         end else if (w.key_code == KEY_DOWN) begin
            pred_menu = pred_menu + 2'd1;
            hz = gate_hz(TONE_DOWN);
            ev = EV_SCROLLED;
         end
      end else if (w.key_code <= KEY_LAST_DIGIT) begin
         pred_entry[pred_count[1:0]] = w.key_code;
         pred_count = pred_count + 3'd1;
         hz = gate_hz(DIGIT_HZ[w.key_code]);
         ev = EV_DIGIT;
         if (pred_count >= CODE_DIGITS) begin
            pred_count = '0;
            if (pred_mode == MODE_SET || pred_mode == MODE_NEW) begin
               pred_code = pred_entry;
               pred_code_valid = 1'b1;
               pred_mode = MODE_IDLE;
               ev = EV_STORED;
            end else if (pred_code == pred_entry) begin
               pred_failed = '0;
               if (pred_mode == MODE_VERIFY) begin
                  pred_mode = MODE_IDLE;
                  ev = EV_OPEN;
               end else begin
                  pred_mode = MODE_NEW;
                  ev = EV_OLD_OK;
               end
            end else if (pred_mode == MODE_VERIFY) begin
               if (pred_failed < 4'd15) pred_failed = pred_failed + 4'd1;
               if (pred_failed >= cfg_max_tries) begin
                  pred_failed = '0;
                  pred_mode = MODE_LOCKED;
                  pred_lock_left = cfg_lockout;
                  hz = gate_hz(TONE_LOCKOUT);
                  ev = EV_LOCKED;
               end else begin
                  pred_mode = MODE_IDLE;
                  hz = gate_hz(TONE_WRONG);
                  ev = EV_WRONG;
               end
            end else begin
               pred_mode = MODE_IDLE;
               hz = gate_hz(TONE_WRONG);
               ev = EV_WRONG;
            end
         end
      end
      r.event_res = ev;
      r.tone_hz = hz;
      r.menu_position = pred_menu;
      r.sound_enabled = pred_sound;
      r.digits_entered = pred_count;
      r.lock_mode = pred_mode;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (lock_results.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            want_word = lock_results.pop_front();
            check_field("event_res", 16'(want_word.event_res), 16'(rsp_word.event_res));
            check_field("tone_hz", 16'(want_word.tone_hz), 16'(rsp_word.tone_hz));
            check_field("menu_position", 16'(want_word.menu_position),
                        16'(rsp_word.menu_position));
            check_field("sound_enabled", 16'(want_word.sound_enabled),
                        16'(rsp_word.sound_enabled));
            check_field("digits_entered", 16'(want_word.digits_entered),
                        16'(rsp_word.digits_entered));
            check_field("lock_mode", 16'(want_word.lock_mode), 16'(rsp_word.lock_mode));
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic op, input logic [3:0] key);
      req_word_type w;
      rsp_word_type want;
      w.op = op;
      w.key_code = key;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      want = predict_lock(w);
      lock_results.push_back(want);
   endtask

   task automatic send_digits(input logic [CODE_DIGITS-1:0][3:0] code);
      for (int i = CODE_DIGITS - 1; i >= 0; i--) send_word(OP_KEY, code[i]);
   endtask

   task automatic drain_words;
      @(negedge clock);
      req_valid <= 1'b0;
      while (lock_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] value);
      drain_words();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_FAILED_TRIES) cfg_max_tries = value[3:0];
      else cfg_lockout = value;
   endtask

   task automatic set_limits(input logic [3:0] tries, input logic [15:0] ticks);
      write_csr(CSR_MAX_FAILED_TRIES, {12'd0, tries});
      write_csr(CSR_LOCKOUT_TICKS, ticks);
   endtask

   task automatic test_idle_keys;
      send_word(OP_TICK, 4'd0);
      send_word(OP_KEY, 4'd0);
      send_word(OP_KEY, 4'd15);
      send_word(OP_KEY, 4'd10);
      send_word(OP_KEY, KEY_DOWN);
      send_word(OP_KEY, KEY_VERIFY);
      send_word(OP_KEY, KEY_CHANGE);
   endtask

   // non-digit keys in the middle of an entry are ignored
   task automatic test_set_code;
      send_word(OP_KEY, KEY_SET);
      send_word(OP_KEY, 4'd9);
      send_word(OP_KEY, 4'd10);
      send_word(OP_KEY, 4'd0);
      send_word(OP_KEY, KEY_DOWN);
      send_word(OP_KEY, 4'd5);
      send_word(OP_KEY, 4'd7);
      send_word(OP_KEY, KEY_SET);
   endtask

   task automatic test_change_code;
      send_word(OP_KEY, KEY_CHANGE);
      send_digits({4'd9, 4'd0, 4'd5, 4'd7});
      send_digits({4'd1, 4'd2, 4'd3, 4'd4});
      send_word(OP_KEY, KEY_SOUND);
   endtask

   // zero limit locks on the first failure, zero ticks acts as one
   task automatic test_lockout;
      set_limits(4'd0, 16'd0);
      send_word(OP_KEY, KEY_VERIFY);
      send_digits({4'd0, 4'd0, 4'd0, 4'd0});
      send_word(OP_KEY, KEY_VERIFY);
      send_word(OP_TICK, 4'd0);
   endtask

   task automatic random_word;
      int pick;
      logic [3:0] digit;
      pick = $urandom_range(0, 99);
      if (pred_mode == MODE_LOCKED) begin
         if (pick < 85) send_word(OP_TICK, 4'($urandom_range(0, 15)));
         else send_word(OP_KEY, 4'($urandom_range(0, 15)));
      end else if (pred_mode == MODE_IDLE) begin
         if (pick < 40) begin
            match_plan = ($urandom_range(0, 2) != 0);
            send_word(OP_KEY, KEY_VERIFY);
         end else if (pick < 52) begin
            match_plan = ($urandom_range(0, 2) != 0);
            send_word(OP_KEY, KEY_CHANGE);
         end else if (pick < 56) begin
            send_word(OP_KEY, KEY_SET);
         end else if (pick < 64) begin
            send_word(OP_KEY, KEY_SOUND);
         end else if (pick < 74) begin
            send_word(OP_KEY, KEY_DOWN);
         end else begin
            send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end
      end else if (pick < 8) begin
         send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else begin
         digit = 4'($urandom_range(0, 9));
         if (match_plan && (pred_mode == MODE_VERIFY || pred_mode == MODE_OLD))
            digit = pred_code[pred_count[1:0]];
         send_word(OP_KEY, digit);
      end
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_limits(4'd15, 16'd1);
            1: set_limits(4'd1, 16'd20);
            2: set_limits(4'd2, 16'd7);
            default: set_limits(4'($urandom_range(0, 15)), 16'($urandom_range(1, 20)));
         endcase
         idle_on = (phase != 4);
         for (int n = 0; n < WORDS_PER_PHASE; n++) random_word();
      end
   endtask

   // full-width lockout length, counted down part of the way
   task automatic test_long_lockout;
      set_limits(4'd1, 16'hFFFF);
      while (pred_mode != MODE_IDLE) begin
         if (pred_mode == MODE_LOCKED) send_word(OP_TICK, 4'd0);
         else send_word(OP_KEY, pred_code[pred_count[1:0]]);
      end
      send_word(OP_KEY, KEY_VERIFY);
      send_digits(pred_code ^ 16'h0001);
      send_word(OP_KEY, KEY_SET);
      repeat (40) send_word(OP_TICK, 4'd0);
      send_word(OP_KEY, KEY_DOWN);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_idle_keys();
      test_set_code();
      test_change_code();
      test_lockout();
      test_random();
      test_long_lockout();
      drain_words();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
